FILE: rtl/lpsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_pkg: shared types and constants of the length-prefixed string codec
// Holds the channel field widths, the character codes, the controller state
// type and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lpsc_pkg;

   localparam int LENGTH_BITS_DEFAULT = 20;
   localparam int STR_LEN_W           = 20;
   localparam int BYTE_W              = 8;

   localparam logic [7:0] HASH_CHAR = 8'h23;
   localparam logic [7:0] ZERO_CHAR = 8'h30;
   localparam logic [7:0] NINE_CHAR = 8'h39;
   localparam int         RADIX     = 10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_DIGITS,
      ST_HASH
   } lpsc_state_type;

   typedef struct packed {
      logic item_take;
      logic conv_load;
      logic conv_step;
      logic digit_emit;
      logic digit_drop;
      logic hash_emit;
   } lpsc_cmd_type;

   typedef struct packed {
      logic encode;
      logic start_item;
      logic out_free;
      logic top_zero;
   } lpsc_sts_type;

   // number of decimal digits of the largest length of the given width
   function automatic int dec_digits(input int bits);
      logic [63:0] v;
      int          n;
      begin
         v = (64'd1 << bits) - 64'd1;
         n = 0;
         for (int i = 0; i < 20; i++) begin
            if (v != 64'd0) begin
               n = n + 1;
               v = v / RADIX;
            end
         end
         return (n < 1) ? 1 : n;
      end
   endfunction

endpackage
`default_nettype wire

FILE: rtl/lpsc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_req_if: request channel of the codec
// Valid/ready channel carrying the item kind, the byte and the value length.
// ----------------------------------------------------------------------------
interface lpsc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            func;
   logic [lpsc_pkg::BYTE_W-1:0]     data_byte;
   logic [lpsc_pkg::STR_LEN_W-1:0]  str_length;

   modport source (output valid, output func, output data_byte, output str_length,
                   input ready);
   modport sink   (input valid, input func, input data_byte, input str_length,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/lpsc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_rsp_if: response channel of the codec
// Valid/ready channel carrying one emitted byte and its marks per beat.
// ----------------------------------------------------------------------------
interface lpsc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lpsc_pkg::BYTE_W-1:0] out_byte;
   logic                        byte_valid;
   logic                        end_of_value;
   logic                        last;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_value, output last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input end_of_value, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/lpsc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_datapath: codec datapath
// Direction register, decoder header/payload state, binary-to-BCD shifter for
// encode headers and the response output register.
// ----------------------------------------------------------------------------
module lpsc_datapath #(
   parameter int LENGTH_BITS = lpsc_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic                            csr_wr_data,
   input  wire logic                            req_func,
   input  wire logic [lpsc_pkg::BYTE_W-1:0]     req_data_byte,
   input  wire logic [lpsc_pkg::STR_LEN_W-1:0]  req_str_length,
   input  wire lpsc_pkg::lpsc_cmd_type          cmd,
   output lpsc_pkg::lpsc_sts_type               sts,
   lpsc_rsp_if.source                           rsp
);

   localparam int NUM_DIGITS = lpsc_pkg::dec_digits(LENGTH_BITS);
   localparam int BCD_W      = NUM_DIGITS * 4;
   localparam int CMP_W      = (LENGTH_BITS > lpsc_pkg::STR_LEN_W) ?
                               LENGTH_BITS : lpsc_pkg::STR_LEN_W;
   localparam int PROD_W     = LENGTH_BITS + 4;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   logic                         direction_ff, direction_in;
   logic                         in_payload_ff, in_payload_in;
   logic [LENGTH_BITS-1:0]       acc_ff, acc_in;
   logic [LENGTH_BITS-1:0]       remain_ff, remain_in;
   logic [LENGTH_BITS-1:0]       conv_ff, conv_in;
   logic [BCD_W-1:0]             bcd_ff, bcd_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lpsc_pkg::BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic                         byte_valid_ff, byte_valid_in;
   logic                         eov_ff, eov_in;
   logic                         last_ff, last_in;

   logic                         out_load;
   logic [BCD_W-1:0]             bcd_adj;
   logic [CMP_W-1:0]             slen_ext;
   logic [PROD_W-1:0]            acc_next;
   logic [LENGTH_BITS-1:0]       remain_dec;
   logic [3:0]                   top_digit;

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   assign sts.encode     = !direction_ff;
   assign sts.start_item = !direction_ff && req_func;
   assign sts.out_free   = !rsp_valid_ff || rsp.ready;
   assign sts.top_zero   = (top_digit == 4'd0);

   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         bcd_adj[d*4 +: 4] = (bcd_ff[d*4 +: 4] >= 4'd5) ?
                             bcd_ff[d*4 +: 4] + 4'd3 : bcd_ff[d*4 +: 4];
      end
   end

   assign slen_ext   = CMP_W'(req_str_length);
   assign acc_next   = (PROD_W'(acc_ff) << 3) + (PROD_W'(acc_ff) << 1)
                     + PROD_W'(req_data_byte - lpsc_pkg::ZERO_CHAR);
   assign remain_dec = (remain_ff == '0) ? '0 : remain_ff - 1'b1;

   always_comb begin
      direction_in  = direction_ff;
      in_payload_in = in_payload_ff;
      acc_in        = acc_ff;
      remain_in     = remain_ff;
      conv_in       = conv_ff;
      bcd_in        = bcd_ff;
      out_load      = 1'b0;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      eov_in        = eov_ff;
      last_in       = last_ff;

      if (csr_wr_en) begin
         direction_in  = csr_wr_data;
         in_payload_in = 1'b0;
         acc_in        = '0;
         remain_in     = '0;
      end

      if (cmd.conv_load) begin
         conv_in = (slen_ext > CMP_W'(LEN_MAX)) ? LEN_MAX : LENGTH_BITS'(slen_ext);
         bcd_in  = '0;
      end

      if (cmd.conv_step) begin
         bcd_in  = {bcd_adj[BCD_W-2:0], conv_ff[LENGTH_BITS-1]};
         conv_in = conv_ff << 1;
      end

      if (cmd.digit_drop) begin
         bcd_in = bcd_ff << 4;
      end

      if (cmd.digit_emit) begin
         bcd_in        = bcd_ff << 4;
         out_load      = 1'b1;
         out_byte_in   = lpsc_pkg::ZERO_CHAR + {4'd0, top_digit};
         byte_valid_in = 1'b1;
         eov_in        = 1'b0;
         last_in       = 1'b0;
      end

      if (cmd.hash_emit) begin
         out_load      = 1'b1;
         out_byte_in   = lpsc_pkg::HASH_CHAR;
         byte_valid_in = 1'b1;
         eov_in        = 1'b0;
         last_in       = 1'b1;
      end

      if (cmd.item_take) begin
         if (!direction_ff) begin
            // encode data byte: pass through
            out_load      = 1'b1;
            out_byte_in   = req_data_byte;
            byte_valid_in = 1'b1;
            eov_in        = 1'b0;
            last_in       = 1'b1;
         end else if (in_payload_ff) begin
            remain_in     = remain_dec;
            out_load      = 1'b1;
            out_byte_in   = req_data_byte;
            byte_valid_in = 1'b1;
            eov_in        = (remain_dec == '0);
            last_in       = 1'b1;
            if (remain_dec == '0) begin
               in_payload_in = 1'b0;
            end
         end else if (req_data_byte inside {[lpsc_pkg::ZERO_CHAR:lpsc_pkg::NINE_CHAR]}) begin
            // saturate the header length
            acc_in = (acc_next > PROD_W'(LEN_MAX)) ? LEN_MAX : LENGTH_BITS'(acc_next);
         end else if (req_data_byte == lpsc_pkg::HASH_CHAR) begin
            if (acc_ff == '0) begin
               out_load      = 1'b1;
               out_byte_in   = '0;
               byte_valid_in = 1'b0;
               eov_in        = 1'b1;
               last_in       = 1'b1;
            end else begin
               remain_in     = acc_ff;
               acc_in        = '0;
               in_payload_in = 1'b1;
            end
         end
      end

      rsp_valid_in = out_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff  <= 1'b0;
         in_payload_ff <= 1'b0;
         acc_ff        <= '0;
         remain_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         direction_ff  <= direction_in;
         in_payload_ff <= in_payload_in;
         acc_ff        <= acc_in;
         remain_ff     <= remain_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      conv_ff       <= conv_in;
      bcd_ff        <= bcd_in;
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      eov_ff        <= eov_in;
      last_ff       <= last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_byte     = out_byte_ff;
   assign rsp.byte_valid   = byte_valid_ff;
   assign rsp.end_of_value = eov_ff;
   assign rsp.last         = last_ff;

endmodule
`default_nettype wire

FILE: rtl/lpsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_ctrl: codec controller
// Takes items, runs the bit-serial length conversion and sequences the
// header digits and the '#' of an encode start item.
// ----------------------------------------------------------------------------
module lpsc_ctrl #(
   parameter int LENGTH_BITS = lpsc_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire lpsc_pkg::lpsc_sts_type  sts,
   output lpsc_pkg::lpsc_cmd_type       cmd
);

   localparam int NUM_DIGITS = lpsc_pkg::dec_digits(LENGTH_BITS);
   localparam int BIT_CNT_W  = $clog2(LENGTH_BITS);
   localparam int DIG_CNT_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   lpsc_pkg::lpsc_state_type state_ff, state_in;
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]     dig_cnt_ff, dig_cnt_in;
   logic                     started_ff, started_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lpsc_pkg::ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
         started_ff <= started_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      started_in = started_ff;
      cmd        = '0;
      req_ready  = 1'b0;

      case (state_ff)
         lpsc_pkg::ST_IDLE: begin
            req_ready = sts.out_free;
            if (req_valid && sts.out_free) begin
               if (sts.start_item) begin
                  cmd.conv_load = 1'b1;
                  bit_cnt_in    = '0;
                  state_in      = lpsc_pkg::ST_CONVERT;
               end else begin
                  cmd.item_take = 1'b1;
               end
            end
         end
         lpsc_pkg::ST_CONVERT: begin
            cmd.conv_step = 1'b1;
            bit_cnt_in    = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(LENGTH_BITS - 1)) begin
               dig_cnt_in = DIG_CNT_W'(NUM_DIGITS - 1);
               started_in = 1'b0;
               state_in   = lpsc_pkg::ST_DIGITS;
            end
         end
         lpsc_pkg::ST_DIGITS: begin
            if (sts.top_zero && !started_ff && dig_cnt_ff != '0) begin
               // drop a leading zero
               cmd.digit_drop = 1'b1;
               dig_cnt_in     = dig_cnt_ff - 1'b1;
            end else if (sts.out_free) begin
               cmd.digit_emit = 1'b1;
               started_in     = 1'b1;
               if (dig_cnt_ff == '0) begin
                  state_in = lpsc_pkg::ST_HASH;
               end else begin
                  dig_cnt_in = dig_cnt_ff - 1'b1;
               end
            end
         end
         lpsc_pkg::ST_HASH: begin
            if (sts.out_free) begin
               cmd.hash_emit = 1'b1;
               state_in      = lpsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpsc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/length_prefixed_string_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_string_codec: length-prefixed string encoder/decoder
// Encodes values as decimal length, '#', raw bytes, or decodes such a stream.
// ----------------------------------------------------------------------------
// Decode-mode stream bytes and encode-mode data bytes are taken one per cycle
// while the response side keeps up; a beat waiting in the response register
// holds off the request side until it is taken. An encode start item is
// accepted, its length goes through bit-serial binary-to-BCD conversion, then
// each decimal digit position of the largest length is emitted or, as a
// leading zero, dropped (one per cycle), and the '#' follows; each emitted
// digit and the '#' also wait for a free response register. Direction is
// written by the user through csr_wr_en/csr_wr_data while the block is idle,
// not enforced by the block; a write also clears the decoder back to header.
module length_prefixed_string_codec #(
   parameter int LENGTH_BITS = lpsc_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_wr_en,
   input  wire logic  csr_wr_data,
   lpsc_req_if.sink   req_bus,
   lpsc_rsp_if.source rsp_bus
);

   lpsc_pkg::lpsc_cmd_type cmd;
   lpsc_pkg::lpsc_sts_type sts;

   lpsc_ctrl #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpsc_datapath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_func       (req_bus.func),
      .req_data_byte  (req_bus.data_byte),
      .req_str_length (req_bus.str_length),
      .cmd            (cmd),
      .sts            (sts),
      .rsp            (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   // a beat is only taken when the response register can hold its result
   a_ready_needs_slot: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("request taken without a free response slot");

   // an encode start holds off the request side while its header is built
   a_start_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.func && sts.encode)
      |=> !req_bus.ready)
      else $error("request taken during encode header");

   // end-of-value marks come only from the decoder
   a_eov_decode: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.end_of_value) |-> !sts.encode)
      else $error("end of value in encode mode");

   // an empty-value marker closes both the value and the item
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.byte_valid) |-> (rsp_bus.end_of_value && rsp_bus.last))
      else $error("malformed empty-value marker");
`endif

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for length_prefixed_string_codec
// Feeds encode and decode traffic through the request channel, predicts
// every response beat in-bench and compares each beat field by field, with
// random idling on both channels, a long response stall and a sender pause.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          LEN_BITS       = lpsc_pkg::LENGTH_BITS_DEFAULT;
   localparam int          BYTE_W         = lpsc_pkg::BYTE_W;
   localparam int          STR_LEN_W      = lpsc_pkg::STR_LEN_W;
   localparam logic        DIR_ENCODE     = 1'b0;
   localparam logic        DIR_DECODE     = 1'b1;
   localparam logic        FUNC_DATA      = 1'b0;
   localparam logic        FUNC_START     = 1'b1;
   localparam int          SETTLE_CYCLES  = 64;
   localparam int          STALL_CYCLES   = 150;
   localparam int          WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic                 func;
      logic [BYTE_W-1:0]    data_byte;
      logic [STR_LEN_W-1:0] str_length;
   } codec_item_type;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              end_of_value;
      logic              last;
   } codec_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   lpsc_req_if req_bus ();
   lpsc_rsp_if rsp_bus ();

   length_prefixed_string_codec #(
      .LENGTH_BITS(LEN_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   codec_item_type req_backlog[$];
   codec_beat_type expected_beats[$];

   // shadow state of the codec
   logic                dir_shadow;
   logic                payload_shadow;
   logic [LEN_BITS-1:0] header_len_shadow;
   logic [LEN_BITS-1:0] remaining_shadow;

   logic req_fire;
   logic no_idle;
   int   stall_asks;
   int   stall_seen;
   int   stall_left;
   int   items_queued;
   int   mismatch_count;
   int   quiet_cycles;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void add_beat(input logic [BYTE_W-1:0] b, input logic bv,
                                    input logic eov, input logic lst);
      codec_beat_type beat;
      beat.out_byte     = b;
      beat.byte_valid   = bv;
      beat.end_of_value = eov;
      beat.last         = lst;
      expected_beats.insert(expected_beats.size(), beat);
   endfunction

   // work out the beats that one accepted item causes and advance the shadow
   function automatic void forecast_codec_output(input codec_item_type it);
      logic [63:0]       len_max;
      logic [63:0]       v;
      logic [63:0]       acc;
      logic [BYTE_W-1:0] digs[$];
      logic              eov;
      len_max = (64'd1 << LEN_BITS) - 64'd1;
      if (dir_shadow == DIR_ENCODE) begin
         if (it.func == FUNC_START) begin
            v = 64'(it.str_length);
            if (v > len_max) v = len_max;
            do begin
               digs.push_front(BYTE_W'(lpsc_pkg::ZERO_CHAR + v % lpsc_pkg::RADIX));
               v = v / lpsc_pkg::RADIX;
            end while (v != 64'd0);
            foreach (digs[k]) add_beat(digs[k], 1'b1, 1'b0, 1'b0);
            add_beat(lpsc_pkg::HASH_CHAR, 1'b1, 1'b0, 1'b1);
         end else begin
            add_beat(it.data_byte, 1'b1, 1'b0, 1'b1);
         end
      end else if (payload_shadow) begin
         if (remaining_shadow != '0) remaining_shadow = remaining_shadow - 1'b1;
         eov = (remaining_shadow == '0);
         if (eov) payload_shadow = 1'b0;
         add_beat(it.data_byte, 1'b1, eov, 1'b1);
      end else if (it.data_byte >= lpsc_pkg::ZERO_CHAR &&
                   it.data_byte <= lpsc_pkg::NINE_CHAR) begin
         acc = 64'(header_len_shadow) * lpsc_pkg::RADIX
             + 64'(it.data_byte - lpsc_pkg::ZERO_CHAR);
         if (acc > len_max) acc = len_max;
         header_len_shadow = LEN_BITS'(acc);
      end else if (it.data_byte == lpsc_pkg::HASH_CHAR) begin
         if (header_len_shadow == '0) begin
            add_beat('0, 1'b0, 1'b1, 1'b1);
         end else begin
            remaining_shadow  = header_len_shadow;
            header_len_shadow = '0;
            payload_shadow    = 1'b1;
         end
      end
   endfunction

   function automatic logic [BYTE_W-1:0] random_non_digit(input logic allow_hash);
      logic [BYTE_W-1:0] b;
      do begin
         b = BYTE_W'($urandom_range(255));
      end while ((b >= lpsc_pkg::ZERO_CHAR && b <= lpsc_pkg::NINE_CHAR) ||
                 (!allow_hash && b == lpsc_pkg::HASH_CHAR));
      return b;
   endfunction

   task automatic push_item(input logic f, input logic [BYTE_W-1:0] b,
                            input logic [STR_LEN_W-1:0] len);
      codec_item_type it;
      it.func       = f;
      it.data_byte  = b;
      it.str_length = len;
      req_backlog.insert(req_backlog.size(), it);
      items_queued++;
   endtask

   // decode-mode byte: func and str_length are don't-care, so scramble them
   task automatic push_stream_byte(input logic [BYTE_W-1:0] b);
      push_item(1'($urandom_range(1)), b, STR_LEN_W'($urandom));
   endtask

   task automatic push_decimal(input int unsigned n);
      string s;
      s = $sformatf("%0d", n);
      for (int i = 0; i < s.len(); i++) push_stream_byte(s[i]);
   endtask

   task automatic write_direction(input logic d);
      @(negedge clock);
      csr_wr_en         = 1'b1;
      csr_wr_data       = d;
      dir_shadow        = d;
      payload_shadow    = 1'b0;
      header_len_shadow = '0;
      remaining_shadow  = '0;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic wait_settled();
      while (req_backlog.size() != 0 || expected_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly well-formed values, the rest noise and headers with junk inside
   task automatic decode_burst(input int count);
      int          stop_at;
      int          r;
      int unsigned n;
      string       s;
      stop_at = items_queued + count;
      while (items_queued < stop_at) begin
         r = $urandom_range(99);
         if (r < 15) begin
            push_stream_byte(random_non_digit(1'b1));
         end else begin
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
            s = $sformatf("%0d", n);
            if ($urandom_range(7) == 0) s = {"0", s};
            for (int i = 0; i < s.len(); i++) begin
               push_stream_byte(s[i]);
               if (r < 25 && i == 0) push_stream_byte(random_non_digit(1'b0));
            end
            push_stream_byte(lpsc_pkg::HASH_CHAR);
            repeat (n) push_stream_byte(BYTE_W'($urandom_range(255)));
         end
      end
   endtask

   // request driver: hold an offered beat until taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_fire) begin
      end else if (req_backlog.size() != 0 && (no_idle || $urandom_range(99) >= 20)) begin
         req_bus.valid      <= 1'b1;
         req_bus.func       <= req_backlog[0].func;
         req_bus.data_byte  <= req_backlog[0].data_byte;
         req_bus.str_length <= req_backlog[0].str_length;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // response driver: random backpressure plus long stalls on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_asks != stall_seen) begin
         stall_seen = stall_asks;
         stall_left = STALL_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= no_idle || ($urandom_range(99) >= 20);
      end
   end

   // request monitor: predict on every accepted beat
   always @(posedge clock) begin
      codec_item_type taken;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            taken.func       = req_bus.func;
            taken.data_byte  = req_bus.data_byte;
            taken.str_length = req_bus.str_length;
            forecast_codec_output(taken);
            void'(req_backlog.pop_front());
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      codec_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected beat, expected none, actual byte=%h bv=%b eov=%b last=%b",
                     $realtime, rsp_bus.out_byte, rsp_bus.byte_valid,
                     rsp_bus.end_of_value, rsp_bus.last);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_bus.out_byte !== want.out_byte ||
                rsp_bus.byte_valid !== want.byte_valid ||
                rsp_bus.end_of_value !== want.end_of_value ||
                rsp_bus.last !== want.last) begin
               mismatch_count++;
               $display("%0t: expected byte=%h bv=%b eov=%b last=%b, %s",
                        $realtime, want.out_byte, want.byte_valid, want.end_of_value,
                        want.last,
                        $sformatf("actual byte=%h bv=%b eov=%b last=%b",
                                  rsp_bus.out_byte, rsp_bus.byte_valid,
                                  rsp_bus.end_of_value, rsp_bus.last));
            end
         end
      end
   end

   // watchdog: count cycles without any beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("length_prefixed_string_codec: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.func       = 1'b0;
      req_bus.data_byte  = '0;
      req_bus.str_length = '0;
      rsp_bus.ready      = 1'b0;
      req_fire           = 1'b0;
      no_idle            = 1'b0;
      stall_asks         = 0;
      stall_seen         = 0;
      stall_left         = 0;
      items_queued       = 0;
      mismatch_count     = 0;
      quiet_cycles       = 0;
      dir_shadow         = DIR_ENCODE;
      payload_shadow     = 1'b0;
      header_len_shadow  = '0;
      remaining_shadow   = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed encode: length extremes, digit-count boundary, data bytes
      write_direction(DIR_ENCODE);
      push_item(FUNC_START, BYTE_W'($urandom), '0);
      push_item(FUNC_START, BYTE_W'($urandom), '1);
      push_item(FUNC_START, BYTE_W'($urandom), STR_LEN_W'(10));
      push_item(FUNC_DATA, 8'h00, STR_LEN_W'($urandom));
      push_item(FUNC_DATA, 8'hFF, STR_LEN_W'($urandom));
      push_item(FUNC_START, BYTE_W'($urandom), STR_LEN_W'(9));
      wait_settled();

      // directed decode: empty value, payload with hash and 0xFF, strays,
      // start flag ignored, and a header that saturates
      write_direction(DIR_DECODE);
      push_decimal(0);
      push_stream_byte(lpsc_pkg::HASH_CHAR);
      push_decimal(2);
      push_stream_byte(lpsc_pkg::HASH_CHAR);
      push_stream_byte(lpsc_pkg::HASH_CHAR);
      push_stream_byte(8'hFF);
      push_stream_byte(8'h2F);
      push_stream_byte(8'h3A);
      push_item(FUNC_START, "1", STR_LEN_W'($urandom));
      push_item(FUNC_START, lpsc_pkg::HASH_CHAR, STR_LEN_W'($urandom));
      push_item(FUNC_START, 8'h00, STR_LEN_W'($urandom));
      push_decimal(9999999);
      push_stream_byte(lpsc_pkg::HASH_CHAR);
      push_stream_byte(8'h00);
      wait_settled();

      // random encode; the direction write drops the saturated payload.
      // A long response stall backs the block up into its input.
      write_direction(DIR_ENCODE);
      stall_asks = stall_asks + 1;
      repeat (85) begin
         if ($urandom_range(99) < 30) begin
            case ($urandom_range(9))
               0:       push_item(FUNC_START, BYTE_W'($urandom), STR_LEN_W'($urandom));
               1, 2:    push_item(FUNC_START, BYTE_W'($urandom),
                                  STR_LEN_W'($urandom_range(99999)));
               default: push_item(FUNC_START, BYTE_W'($urandom),
                                  STR_LEN_W'($urandom_range(99)));
            endcase
         end else begin
            push_item(FUNC_DATA, BYTE_W'($urandom), STR_LEN_W'($urandom));
         end
      end
      wait_settled();

      // random decode in two bursts; pause for a full drain between them,
      // and run the second without any idling
      write_direction(DIR_DECODE);
      decode_burst(60);
      wait_settled();
      no_idle = 1'b1;
      decode_burst(60);
      wait_settled();
      no_idle = 1'b0;

      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("length_prefixed_string_codec: match");
      end else begin
         $display("length_prefixed_string_codec: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/lpsc_pkg.sv
rtl/lpsc_req_if.sv
rtl/lpsc_rsp_if.sv
rtl/lpsc_datapath.sv
rtl/lpsc_ctrl.sv
rtl/length_prefixed_string_codec.sv
test/tb_top.sv
